/* hw/rtl/block_bitmap_allocator_unit_macros.svh */
// Assertion macros for the block bitmap allocator checker.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

/* hw/rtl/bba_pkg.sv */
// Shared constants, codes and types of the block bitmap allocator.
package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LAST_WORD  = NUM_WORDS - 1;
  localparam int LAST_BITS  = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Real blocks held in the last bitmap word.
  localparam logic [WORD_W-1:0] LAST_MASK =
    (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << LAST_BITS) - 64'd1);

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_USE   = 2'd1,
    OP_FREE  = 2'd2,
    OP_ALLOC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } seq_state_e;

  typedef struct packed {
    logic               re;
    logic [WADDR_W-1:0] raddr;
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
  } store_req_t;

  typedef struct packed {
    logic              bit_val;
    logic              found;
    logic [BIT_W-1:0]  pos;
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] clr_word;
    logic [WORD_W-1:0] alloc_word;
  } word_res_t;

endpackage

/* hw/rtl/bba_bitmap_store.sv */
// Bitmap word memory with per-word valid bits and a registered read port.
module bba_bitmap_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bba_pkg::store_req_t          req_i,
  output logic [bba_pkg::WORD_W-1:0]   rd_word_o
);
  import bba_pkg::*;

  logic [WORD_W-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  // A word never written reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_word_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* hw/rtl/bba_word_unit.sv */
// Shared word unit: bit test, set, clear and first-free search on one bitmap word.
module bba_word_unit (
  input  logic [bba_pkg::WORD_W-1:0] word_i,
  input  logic [bba_pkg::BIT_W-1:0]  bit_sel_i,
  input  logic                       last_i,
  output bba_pkg::word_res_t         res_o
);
  import bba_pkg::*;

  logic [WORD_W-1:0] sel;
  logic [WORD_W-1:0] avail;
  logic [WORD_W-1:0] lowbit;
  logic [BIT_W-1:0]  pos;

  assign sel    = WORD_W'(1) << bit_sel_i;
  // Ignore bit positions past the last real block.
  assign avail  = ~word_i & (last_i ? LAST_MASK : {WORD_W{1'b1}});
  assign lowbit = avail & (~avail + WORD_W'(1));

  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    res_o.bit_val    = |(word_i & sel);
    res_o.found      = |avail;
    res_o.pos        = pos;
    res_o.set_word   = word_i | sel;
    res_o.clr_word   = word_i & ~sel;
    res_o.alloc_word = word_i | lowbit;
  end

endmodule

/* hw/rtl/block_bitmap_allocator_unit.sv */
// Top level of the block bitmap allocator: sequencer, result registers and datapath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   request  | start / busy          | op_i, block_index_i
//   result   | done_o (1-cycle)      | result_block_o, is_used_o, status_o
//
// A request is taken when start is high and busy is low. Query, mark used and
// mark free take one bitmap word read; done_o pulses once the result of that
// word is registered. An out-of-range index is answered the cycle after
// acceptance. Allocate scans one 32-bit word per cycle through the shared word
// unit over the single read port until a free block is found or the last word
// is seen. The receiver cannot stall; done_o is not held. Reset clears the
// per-word valid bits at once, so the bitmap reads all free with no sweep.
module block_bitmap_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic [bba_pkg::IDX_W-1:0] block_index_i,
  output logic                      done_o,
  output logic [bba_pkg::IDX_W-1:0] result_block_o,
  output logic                      is_used_o,
  output logic [1:0]                status_o
);
  import bba_pkg::*;

  seq_state_e         state_q, state_d;
  op_e                op_q, op_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [WADDR_W-1:0] addr_q, addr_d;
  logic               done_q, done_d;
  logic [IDX_W-1:0]   rblk_q, rblk_d;
  logic               used_q, used_d;
  status_e            status_q, status_d;

  store_req_t         req;
  logic [WORD_W-1:0]  rd_word;
  word_res_t          wres;

  logic               accept;
  logic               in_range;
  logic [WADDR_W-1:0] in_addr;
  logic               last_word;
  logic               scan_done;

  assign accept    = start && (state_q == S_IDLE);
  assign in_range  = CMP_W'(block_index_i) < CMP_W'(NUM_BLOCKS);
  assign in_addr   = WADDR_W'(CMP_W'(block_index_i) >> BIT_W);
  assign last_word = (addr_q == WADDR_W'(LAST_WORD));

  bba_bitmap_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_word_o (rd_word)
  );

  bba_word_unit u_word (
    .word_i    (rd_word),
    .bit_sel_i (idx_q[BIT_W-1:0]),
    .last_i    (last_word),
    .res_o     (wres)
  );

  // The scan state ends unless allocate found nothing and more words remain.
  assign scan_done = (op_q != OP_ALLOC) || wres.found || last_word;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && ((op_e'(op_i) == OP_ALLOC) || in_range)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory requests, operand capture and results.
  always_comb begin
    req      = '0;
    op_d     = op_q;
    idx_d    = idx_q;
    addr_d   = addr_q;
    done_d   = 1'b0;
    rblk_d   = rblk_q;
    used_d   = used_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_e'(op_i);
          idx_d = block_index_i;
          if (op_e'(op_i) == OP_ALLOC) begin
            addr_d    = '0;
            req.re    = 1'b1;
            req.raddr = '0;
          end else if (in_range) begin
            addr_d    = in_addr;
            req.re    = 1'b1;
            req.raddr = in_addr;
          end else begin
            // Reject right away; bitmap untouched.
            done_d   = 1'b1;
            rblk_d   = block_index_i;
            used_d   = 1'b0;
            status_d = ST_RANGE;
          end
        end
      end
      S_SCAN: begin
        req.waddr = addr_q;
        case (op_q)
          OP_QUERY: begin
            done_d   = 1'b1;
            rblk_d   = idx_q;
            used_d   = wres.bit_val;
            status_d = ST_OK;
          end
          OP_USE: begin
            req.we    = 1'b1;
            req.wdata = wres.set_word;
            done_d    = 1'b1;
            rblk_d    = idx_q;
            used_d    = 1'b0;
            status_d  = ST_OK;
          end
          OP_FREE: begin
            req.we    = 1'b1;
            req.wdata = wres.clr_word;
            done_d    = 1'b1;
            rblk_d    = idx_q;
            used_d    = 1'b0;
            status_d  = ST_OK;
          end
          OP_ALLOC: begin
            if (wres.found) begin
              req.we    = 1'b1;
              req.wdata = wres.alloc_word;
              done_d    = 1'b1;
              rblk_d    = IDX_W'({addr_q, wres.pos});
              used_d    = 1'b0;
              status_d  = ST_OK;
            end else if (last_word) begin
              done_d   = 1'b1;
              rblk_d   = '0;
              used_d   = 1'b0;
              status_d = ST_FULL;
            end else begin
              // Advance to the next word; its data arrives next cycle.
              addr_d    = addr_q + WADDR_W'(1);
              req.re    = 1'b1;
              req.raddr = addr_q + WADDR_W'(1);
            end
          end
          default: done_d = 1'b0;
        endcase
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    addr_q   <= addr_d;
    rblk_q   <= rblk_d;
    used_q   <= used_d;
    status_q <= status_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign result_block_o = rblk_q;
  assign is_used_o      = used_q;
  assign status_o       = status_q;

endmodule

/* hw/rtl/bba_checker.sv */
// Port-level checker for the block bitmap allocator, bound to the top level.
`include "block_bitmap_allocator_unit_macros.svh"

module bba_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                op_i,
  input logic [bba_pkg::IDX_W-1:0] block_index_i,
  input logic                      done_o,
  input logic [bba_pkg::IDX_W-1:0] result_block_o,
  input logic                      is_used_o,
  input logic [1:0]                status_o
);
  import bba_pkg::*;

  logic             take;
  logic             bad_index;
  logic [IDX_W-1:0] idx_prev_q;
  logic             range_reply;

  // Hold the index seen at the previous edge for the reject check.
  always_ff @(posedge clk_i) begin
    idx_prev_q <= block_index_i;
  end

  assign take        = start && !busy;
  assign bad_index   = (op_i != OP_ALLOC) && (CMP_W'(block_index_i) >= CMP_W'(NUM_BLOCKS));
  assign range_reply = done_o && (status_o == ST_RANGE) && (result_block_o == idx_prev_q) &&
                       !is_used_o;

  `BBA_ASSERT_NOW(a_done_idle, done_o, !busy)
  `BBA_ASSERT_NEXT(a_alloc_busy, take && (op_i == OP_ALLOC), busy && !done_o)
  `BBA_ASSERT_NEXT(a_range_reply, take && bad_index, range_reply)
  `BBA_ASSERT_NOW(a_full_zero, done_o && (status_o == ST_FULL), (result_block_o == '0) && !is_used_o)

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the block bitmap allocator: directed table and random mix.
`timescale 1ns / 1ps

module tb;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before the watchdog stops the run
  localparam int DRAIN_CYCLES   = 40;    // cycles run after the last reply is checked
  localparam int MIX_ITEMS      = 626;   // random items after the directed table

  // One reply as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0] blk;
    logic             used;
    status_e          st;
  } alloc_reply_t;

  // One row of the directed table; typed rows carry their reply, the rest use the predictor.
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    bit               typed;
    alloc_reply_t     reply;
  } dir_row_t;

  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // fresh map: every block reads free, allocation starts at block 0
    '{OP_QUERY, 10'd0,    1'b1, '{10'd0,    1'b0, ST_OK}},
    '{OP_QUERY, 10'd1023, 1'b1, '{10'd1023, 1'b0, ST_OK}},
    '{OP_QUERY, 10'h2AA,  1'b1, '{10'h2AA,  1'b0, ST_OK}},
    '{OP_ALLOC, 10'd0,    1'b1, '{10'd0,    1'b0, ST_OK}},
    '{OP_ALLOC, 10'd1023, 1'b1, '{10'd1,    1'b0, ST_OK}},
    '{OP_QUERY, 10'd0,    1'b1, '{10'd0,    1'b1, ST_OK}},
    // top block: mark, mark again, clear; then free a block that is already free
    '{OP_USE,   10'd1023, 1'b1, '{10'd1023, 1'b0, ST_OK}},
    '{OP_QUERY, 10'd1023, 1'b1, '{10'd1023, 1'b1, ST_OK}},
    '{OP_USE,   10'd1023, 1'b1, '{10'd1023, 1'b0, ST_OK}},
    '{OP_FREE,  10'd1023, 1'b1, '{10'd1023, 1'b0, ST_OK}},
    '{OP_QUERY, 10'd1023, 1'b1, '{10'd1023, 1'b0, ST_OK}},
    '{OP_FREE,  10'h155,  1'b1, '{10'h155,  1'b0, ST_OK}},
    // holes below the allocation point
    '{OP_USE,   10'd2,    1'b0, '0},
    '{OP_ALLOC, 10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    1'b0, '0},
    '{OP_ALLOC, 10'h155,  1'b0, '0},
    '{OP_QUERY, 10'd2,    1'b0, '0},
    '{OP_USE,   10'h3FE,  1'b0, '0},
    '{OP_FREE,  10'd1,    1'b0, '0},
    '{OP_QUERY, 10'd1,    1'b0, '0},
    '{OP_ALLOC, 10'h3FF,  1'b0, '0},
    '{OP_FREE,  10'd3,    1'b0, '0},
    '{OP_FREE,  10'd2,    1'b0, '0},
    '{OP_ALLOC, 10'h2AA,  1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       op_i;
  logic [IDX_W-1:0] block_index_i;
  logic             done_o;
  logic [IDX_W-1:0] result_block_o;
  logic             is_used_o;
  logic [1:0]       status_o;

  block_bitmap_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .block_index_i  (block_index_i),
    .done_o         (done_o),
    .result_block_o (result_block_o),
    .is_used_o      (is_used_o),
    .status_o       (status_o)
  );

  // Shadow copy of the usage map and the replies still owed by the block.
  bit           block_used [NUM_BLOCKS];
  int           used_count;
  alloc_reply_t pending_replies [$];

  int n_requests;
  int n_replies;
  int n_allocs;
  int n_full;
  int n_errors;
  int idle_cycles;
  bit burst_mode;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one request to the shadow map and return the reply it must produce.
  function automatic alloc_reply_t predict_reply(op_e op, logic [IDX_W-1:0] idx);
    alloc_reply_t r;
    bit           found;
    r.blk  = idx;
    r.used = 1'b0;
    r.st   = ST_OK;
    found  = 1'b0;
    if (op == OP_ALLOC) begin
      // lowest free block wins; a full map leaves everything unchanged
      r.blk = '0;
      r.st  = ST_FULL;
      for (int n = 0; n < NUM_BLOCKS; n++) begin
        if (!found && !block_used[n]) begin
          found         = 1'b1;
          block_used[n] = 1'b1;
          used_count++;
          r.blk = IDX_W'(n);
          r.st  = ST_OK;
        end
      end
    end else if (int'(idx) >= NUM_BLOCKS) begin
      r.st = ST_RANGE;
    end else begin
      case (op)
        OP_QUERY: r.used = block_used[idx];
        OP_USE: begin
          if (!block_used[idx]) used_count++;
          block_used[idx] = 1'b1;
        end
        default: begin
          if (block_used[idx]) used_count--;
          block_used[idx] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // Drive one transaction, hold it until the block takes it, then queue the reply.
  task automatic issue_request(input op_e op, input logic [IDX_W-1:0] idx,
                               input bit typed, input alloc_reply_t typed_reply);
    int           gap;
    alloc_reply_t pred;
    // switch between back-to-back bursts and random gaps every few dozen items
    if (n_requests % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    op_i          <= op;
    block_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = predict_reply(op, idx);
    if (pred.st == ST_FULL) n_full++;
    if (op == OP_ALLOC) n_allocs++;
    pending_replies.push_back(typed ? typed_reply : pred);
    n_requests++;
  endtask

  // Favor the low blocks so frees land where allocation looks first.
  function automatic logic [IDX_W-1:0] pick_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return IDX_W'($urandom_range(0, 63));
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 10'h2AA;
        default: return 10'h155;
      endcase
    end
    return IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  task automatic run_mixed(input int count);
    int  roll;
    op_e op;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) op = OP_ALLOC;
      else if (roll < 60) op = OP_FREE;
      else if (roll < 75) op = OP_USE;
      else op = OP_QUERY;
      // allocate ignores the index, so send raw noise there
      issue_request(op, (op == OP_ALLOC) ? IDX_W'($urandom) : pick_index(), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Compare every reply strobe with the oldest outstanding transaction.
  always @(posedge clk_i) begin : reply_check
    alloc_reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply: expected none, actual block %0d used %0d status %0d",
                 $time, result_block_o, is_used_o, status_o);
        n_errors++;
      end else begin
        want = pending_replies.pop_front();
        check_field("result_block", want.blk, result_block_o);
        check_field("is_used", want.used, is_used_o);
        check_field("status", want.st, status_o);
        n_replies++;
      end
    end
  end

  // Stop a hung block: count cycles with no request taken and no reply seen.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d replies outstanding", $time,
                 pending_replies.size());
        $display("block_bitmap_allocator_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    n_requests    = 0;
    n_replies     = 0;
    n_allocs      = 0;
    n_full        = 0;
    n_errors      = 0;
    used_count    = 0;
    burst_mode    = 1'b0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    op_i          <= OP_QUERY;
    block_index_i <= '0;
    // the map comes out of reset all free
    foreach (block_used[n]) block_used[n] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      issue_request(DIR_TABLE[r].op, DIR_TABLE[r].idx, DIR_TABLE[r].typed, DIR_TABLE[r].reply);
    end

    // Churn a partly used map.
    run_mixed(MIX_ITEMS);

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d allocations, %0d on a full map), %0d replies checked.",
             n_requests, n_allocs, n_full, n_replies);
    $display("%0d of %0d blocks left in use; %0d mismatches found.",
             used_count, NUM_BLOCKS, n_errors);
    if (n_errors == 0 && pending_replies.size() == 0) begin
      $display("block_bitmap_allocator_unit regression: pass");
    end else begin
      $display("block_bitmap_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule
